@@ sv/stable_priority_queue_defines.svh @@
// assertion macros for the checker file of the stable priority queue
// no dependencies; include by bare file name
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// condition implies consequence in the same cycle
`define SPQ_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define SPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/spq_pkg.sv @@
// types and codes shared by the stable priority queue modules
// no dependencies
`timescale 1ns / 1ps

package spq_pkg;

    localparam int PRIO_W = 3;
    localparam int TAG_W  = 8;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [PRIO_W-1:0] priority_level;
        logic [TAG_W-1:0]  entry_tag;
    } t_in_item;

    typedef struct packed {
        logic [TAG_W-1:0]  head_tag;
        logic [PRIO_W-1:0] head_priority;
        logic [STAT_W-1:0] status;
        logic [OCC_W-1:0]  occupancy;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE,
        OP_CLEAR
    } t_dp_op;

    // controller to datapath
    typedef struct packed {
        logic              load;
        logic              exec;
        t_dp_op            op;
        logic [STAT_W-1:0] status;
    } t_dp_ctl;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             full;
        logic             empty;
    } t_dp_stat;

endpackage

@@ sv/spq_ctrl.sv @@
// controller of the stable priority queue: handshakes and operation select
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_ctrl
    import spq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_ctl  o_ctl
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   exec;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    // the update waits until the output register is free or being emptied
    assign exec        = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_ctl.load   = i_in_valid && (r_state == S_IDLE);
        o_ctl.exec   = exec;
        o_ctl.op     = OP_NONE;
        o_ctl.status = ST_OK;
        case (i_stat.command)
            CMD_INSERT: begin
                if (i_stat.full) begin
                    o_ctl.status = ST_FULL;
                end else begin
                    o_ctl.op = OP_INSERT;
                end
            end
            CMD_REMOVE: begin
                if (i_stat.empty) begin
                    o_ctl.status = ST_EMPTY;
                end else begin
                    o_ctl.op = OP_REMOVE;
                end
            end
            CMD_CLEAR: begin
                o_ctl.op = OP_CLEAR;
            end
            default: begin
                o_ctl.op = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_EXEC: begin
                    if (exec) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/spq_datapath.sv @@
// datapath of the stable priority queue: sorted row of entry cells,
// entry count, input and output registers; depends on spq_pkg
`timescale 1ns / 1ps

module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_dp_ctl   i_ctl,
    output t_dp_stat  o_stat,
    output t_out_item o_out_item
);

    localparam int CW = $clog2(DEPTH + 1);

    t_in_item          r_in;
    t_out_item         r_out;
    logic [CW-1:0]     r_fill;
    logic [CW-1:0]     n_fill;
    logic [PRIO_W-1:0] r_prio [DEPTH];
    logic [TAG_W-1:0]  r_tag  [DEPTH];
    logic [DEPTH-1:0]  keep;
    logic [CW+OCC_W-1:0] occ_ext;

    assign o_stat.command = r_in.command;
    assign o_stat.full    = (r_fill == CW'(DEPTH));
    assign o_stat.empty   = (r_fill == '0);
    assign o_out_item     = r_out;

    always_comb begin
        case (i_ctl.op)
            OP_INSERT: n_fill = r_fill + CW'(1);
            OP_REMOVE: n_fill = r_fill - CW'(1);
            OP_CLEAR:  n_fill = '0;
            default:   n_fill = r_fill;
        endcase
    end

    assign occ_ext = {{OCC_W{1'b0}}, n_fill};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_ctl.exec) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_in <= i_in_item;
        end
        if (i_ctl.exec) begin
            r_out.status    <= i_ctl.status;
            r_out.occupancy <= occ_ext[OCC_W-1:0];
            if (i_ctl.op == OP_REMOVE) begin
                r_out.head_tag      <= r_tag[0];
                r_out.head_priority <= r_prio[0];
            end else begin
                r_out.head_tag      <= '0;
                r_out.head_priority <= '0;
            end
        end
    end

    // each cell compares itself with the new entry; the kept cells form a prefix
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        localparam logic [CW-1:0] K = CW'(k);

        assign keep[k] = (K < r_fill) && (r_prio[k] <= r_in.priority_level);

        always_ff @(posedge i_clk) begin
            if (i_ctl.exec) begin
                case (i_ctl.op)
                    OP_INSERT: begin
                        if (!keep[k]) begin
                            if (k == 0) begin
                                r_prio[k] <= r_in.priority_level;
                                r_tag[k]  <= r_in.entry_tag;
                            end else if (keep[(k == 0) ? 0 : k-1]) begin
                                r_prio[k] <= r_in.priority_level;
                                r_tag[k]  <= r_in.entry_tag;
                            end else begin
                                r_prio[k] <= r_prio[(k == 0) ? 0 : k-1];
                                r_tag[k]  <= r_tag[(k == 0) ? 0 : k-1];
                            end
                        end
                    end
                    OP_REMOVE: begin
                        if (k < DEPTH - 1) begin
                            r_prio[k] <= r_prio[(k < DEPTH - 1) ? k+1 : k];
                            r_tag[k]  <= r_tag[(k < DEPTH - 1) ? k+1 : k];
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

@@ sv/stable_priority_queue.sv @@
// Stable priority queue: holds up to DEPTH entries (priority, tag) in a sorted
// row of cells, lowest priority number at the head, equal priorities in
// arrival order. Each input item carries one command (insert, remove head,
// clear) and yields exactly one output item with the removed head (zeros
// otherwise), a status code and the occupancy after the command. The
// command is first captured in the input register; then every cell compares
// and shifts in parallel and the result is registered. The update waits
// while the output register still holds an untaken item, and no new item is
// taken until the current one has been registered at the output.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
`timescale 1ns / 1ps

module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_dp_ctl  ctl;
    t_dp_stat stat;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_ctl       (ctl)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_ctl      (ctl),
        .o_stat     (stat),
        .o_out_item (o_out_item)
    );

endmodule

@@ sv/spq_checker.sv @@
// port-level checker for the stable priority queue, bound to the top level
// depends on spq_pkg and stable_priority_queue_defines.svh
`timescale 1ns / 1ps
`include "stable_priority_queue_defines.svh"

module spq_checker
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

    `SPQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item), "output item changed while stalled")
    `SPQ_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "second item taken while one is in work")
    `SPQ_ASSERT_SAME(a_full_count, i_clk, i_rst_n, o_out_valid && (o_out_item.status == ST_FULL), o_out_item.occupancy == OCC_FULL, "dropped insert without a full queue")
    `SPQ_ASSERT_SAME(a_empty_zero, i_clk, i_rst_n, o_out_valid && (o_out_item.status == ST_EMPTY), (o_out_item.occupancy == '0) && (o_out_item.head_tag == '0) && (o_out_item.head_priority == '0), "empty remove with nonzero result")

endmodule

bind stable_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);
